/* rtl/icm_pkg.sv */
// Shared types, constants and register codes for the incremental conductance tracker.
package icm_pkg;

  // Duty width follows the payload struct, so it is fixed here
  localparam int DUTY_BITS     = 8;
  localparam int FRAC_BITS_DEF = 16;

  localparam int SAMPLE_BITS   = 16;
  localparam int CFG_IDX_BITS  = 3;
  localparam int CFG_DATA_BITS = 16;

  // Configuration register indexes
  localparam logic [CFG_IDX_BITS-1:0] CFG_STEP      = 3'd0;
  localparam logic [CFG_IDX_BITS-1:0] CFG_TOLERANCE = 3'd1;
  localparam logic [CFG_IDX_BITS-1:0] CFG_DUTY_LO   = 3'd2;
  localparam logic [CFG_IDX_BITS-1:0] CFG_DUTY_HI   = 3'd3;
  localparam logic [CFG_IDX_BITS-1:0] CFG_DUTY_INIT = 3'd4;

  // Register reset values
  localparam logic [3:0]  STEP_RST      = 4'd1;
  localparam logic [15:0] TOLERANCE_RST = 16'd655;
  localparam logic [7:0]  DUTY_LO_RST   = 8'd0;
  localparam logic [7:0]  DUTY_HI_RST   = 8'd255;
  localparam logic [7:0]  INIT_DUTY_RST = 8'd127;

  // Action codes reported with each duty
  localparam logic [1:0] ACT_FIRST = 2'd0;
  localparam logic [1:0] ACT_HOLD  = 2'd1;
  localparam logic [1:0] ACT_UP    = 2'd2;
  localparam logic [1:0] ACT_DOWN  = 2'd3;

  typedef struct packed {
    logic        [SAMPLE_BITS-1:0] voltage_mv;
    logic signed [SAMPLE_BITS-1:0] current_ma;
  } in_word_t;

  typedef struct packed {
    logic [DUTY_BITS-1:0] duty;
    logic [1:0]           action;
  } out_word_t;

  typedef struct packed {
    logic [3:0]  duty_step;
    logic [15:0] tolerance_q16;
    logic [7:0]  duty_lo;
    logic [7:0]  duty_hi;
    logic [7:0]  duty_init;
  } cfg_t;

endpackage

/* rtl/mppt_incremental_conductance.sv */
// Incremental conductance MPPT top level: sample control, decision and duty update.
//
//  channel | direction | handshake           | word
//  --------+-----------+---------------------+-------------------------------
//  in_     | input     | in_valid / in_stall | in_word_t  voltage, current
//  out_    | output    | out_valid/out_stall | out_word_t duty, action
//  cfg_    | input     | cfg_valid/cfg_ready | cfg_index, cfg_data
//
// One sample at a time. A sample that needs the two conductance quotients waits on the two
// bit-serial dividers, which run side by side and produce one quotient bit per cycle. The
// first sample and the zero-current, unchanged-voltage and zero-voltage cases skip the
// dividers. Synchronous active-low reset clears control state and loads the register defaults.
// A stalled result holds the next one in the output state and keeps in_stall high until the
// register frees.
module mppt_incremental_conductance
  import icm_pkg::*;
#(
  parameter int FRAC_BITS = FRAC_BITS_DEF
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     in_valid,
  output logic                     in_stall,
  input  in_word_t                 in_word,
  output logic                     out_valid,
  input  logic                     out_stall,
  output out_word_t                out_word,
  input  logic                     cfg_valid,
  output logic                     cfg_ready,
  input  logic [CFG_IDX_BITS-1:0]  cfg_index,
  input  logic [CFG_DATA_BITS-1:0] cfg_data
);

  localparam int QW  = SAMPLE_BITS + FRAC_BITS;
  localparam int SW  = QW + 1;
  localparam int XW  = QW + 2;
  localparam int SHL = (FRAC_BITS >= 16) ? FRAC_BITS - 16 : 0;
  localparam int SHR = (FRAC_BITS >= 16) ? 0 : 16 - FRAC_BITS;
  localparam int DW  = ((DUTY_BITS > 8) ? DUTY_BITS : 8) + 2;

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_PREP = 3'd1;
  localparam logic [2:0] S_DIV  = 3'd2;
  localparam logic [2:0] S_DIFF = 3'd3;
  localparam logic [2:0] S_CMP  = 3'd4;
  localparam logic [2:0] S_UPD  = 3'd5;
  localparam logic [2:0] S_OUT  = 3'd6;

  cfg_t cfg;

  logic [2:0]                    state_r;
  logic                          first_r;
  logic                          was_first_r;
  logic [SAMPLE_BITS-1:0]        prev_v_r;
  logic signed [SAMPLE_BITS-1:0] prev_i_r;
  logic [SAMPLE_BITS-1:0]        v_r;
  logic signed [SAMPLE_BITS-1:0] i_r;
  logic signed [SAMPLE_BITS:0]   dv_r;
  logic signed [SAMPLE_BITS:0]   di_r;
  logic signed [SW-1:0]          inc_r;
  logic signed [SW-1:0]          inst_r;
  logic signed [XW-1:0]          diff_r;
  logic [1:0]                    act_r;
  logic [DUTY_BITS-1:0]          duty_r;
  logic                          out_valid_r;
  out_word_t                     out_word_r;

  logic                          in_take;
  logic                          out_free;
  logic                          go_div;
  logic                          div_start;
  logic signed [SAMPLE_BITS:0]   di_abs;
  logic signed [SAMPLE_BITS:0]   dv_abs;
  logic signed [SAMPLE_BITS:0]   i_abs;
  logic                          inc_done;
  logic                          inst_done;
  logic [QW-1:0]                 inc_q;
  logic [QW-1:0]                 inst_q;
  logic signed [SW-1:0]          inc_mag;
  logic signed [SW-1:0]          inst_mag;
  logic signed [XW-1:0]          tol_s;
  logic                          hold;
  logic signed [DW-1:0]          cand;
  logic signed [DW-1:0]          min_s;
  logic signed [DW-1:0]          max_s;
  logic [DUTY_BITS-1:0]          duty_nxt;

  icm_regs u_regs (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  // Handshake
  assign in_stall  = (state_r != S_IDLE);
  assign in_take   = in_valid && !in_stall;
  assign out_free  = !out_valid_r || !out_stall;
  assign out_valid = out_valid_r;
  assign out_word  = out_word_r;

  // Magnitudes for the dividers
  assign di_abs = di_r[SAMPLE_BITS] ? -di_r : di_r;
  assign dv_abs = dv_r[SAMPLE_BITS] ? -dv_r : dv_r;
  assign i_abs  = i_r[SAMPLE_BITS-1] ? -(SAMPLE_BITS+1)'(i_r) : (SAMPLE_BITS+1)'(i_r);

  // Divide only when no special case decides
  assign go_div    = !was_first_r && (i_r != '0) && (dv_r != '0) && (v_r != '0);
  assign div_start = (state_r == S_PREP) && go_div;

  icm_div #(.FRAC_BITS(FRAC_BITS)) u_div_inc (
    .clk   (clk),
    .rst_n (rst_n),
    .start (div_start),
    .num   (di_abs[SAMPLE_BITS-1:0]),
    .den   (dv_abs[SAMPLE_BITS-1:0]),
    .done  (inc_done),
    .quot  (inc_q)
  );

  icm_div #(.FRAC_BITS(FRAC_BITS)) u_div_inst (
    .clk   (clk),
    .rst_n (rst_n),
    .start (div_start),
    .num   (i_abs[SAMPLE_BITS-1:0]),
    .den   (v_r),
    .done  (inst_done),
    .quot  (inst_q)
  );

  assign inc_mag  = $signed({1'b0, inc_q});
  assign inst_mag = $signed({1'b0, inst_q});

  // Scale tolerance to the quotient's fraction bits
  assign tol_s = $signed(XW'(cfg.tolerance_q16 >> SHR) << SHL);
  assign hold  = diff_r[XW-1] ? (diff_r > -tol_s) : (diff_r < tol_s);

  // Step and saturate the duty, low bound first; the first sample loads the initial duty instead
  assign min_s = $signed(DW'(cfg.duty_lo));
  assign max_s = $signed(DW'(cfg.duty_hi));
  always_comb begin
    cand = $signed(DW'(duty_r));
    case (act_r)
      ACT_UP:   cand = cand + $signed(DW'(cfg.duty_step));
      ACT_DOWN: cand = cand - $signed(DW'(cfg.duty_step));
      default: ;
    endcase
    if (cand < min_s) begin
      cand = min_s;
    end else if (cand > max_s) begin
      cand = max_s;
    end
    if (act_r == ACT_FIRST) begin
      duty_nxt = DUTY_BITS'(cfg.duty_init);
    end else begin
      duty_nxt = cand[DUTY_BITS-1:0];
    end
  end

  // Sequence one sample
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      first_r     <= 1'b1;
      prev_v_r    <= '0;
      prev_i_r    <= '0;
      duty_r      <= DUTY_BITS'(INIT_DUTY_RST);
      out_valid_r <= 1'b0;
    end else begin
      case (state_r)
        S_IDLE: begin
          if (in_take) begin
            state_r  <= S_PREP;
            first_r  <= 1'b0;
            prev_v_r <= in_word.voltage_mv;
            prev_i_r <= in_word.current_ma;
          end
        end
        S_PREP: begin
          state_r <= go_div ? S_DIV : S_UPD;
        end
        S_DIV: begin
          if (inc_done && inst_done) begin
            state_r <= S_DIFF;
          end
        end
        S_DIFF:  state_r <= S_CMP;
        S_CMP:   state_r <= S_UPD;
        S_UPD: begin
          state_r <= S_OUT;
          duty_r  <= duty_nxt;
        end
        S_OUT: begin
          if (out_free) begin
            state_r <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
      // Load a new word, or drop the one taken downstream
      if ((state_r == S_OUT) && out_free) begin
        out_valid_r <= 1'b1;
      end else if (out_valid_r && !out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Hold sample and working values
  always_ff @(posedge clk) begin
    case (state_r)
      S_IDLE: begin
        if (in_take) begin
          was_first_r <= first_r;
          v_r         <= in_word.voltage_mv;
          i_r         <= in_word.current_ma;
          dv_r        <= $signed({1'b0, in_word.voltage_mv}) - $signed({1'b0, prev_v_r});
          di_r        <= $signed({in_word.current_ma[SAMPLE_BITS-1], in_word.current_ma})
                         - $signed({prev_i_r[SAMPLE_BITS-1], prev_i_r});
        end
      end
      S_PREP: begin
        if (was_first_r) begin
          act_r <= ACT_FIRST;
        end else if (i_r == '0) begin
          act_r <= ACT_UP;
        end else if (dv_r == '0) begin
          if (di_r > 0) begin
            act_r <= ACT_UP;
          end else if (di_r < 0) begin
            act_r <= ACT_DOWN;
          end else begin
            act_r <= ACT_HOLD;
          end
        end else if (v_r == '0) begin
          act_r <= ACT_UP;
        end
      end
      S_DIV: begin
        if (inc_done && inst_done) begin
          inc_r  <= (di_r[SAMPLE_BITS] ^ dv_r[SAMPLE_BITS]) ? -inc_mag : inc_mag;
          inst_r <= i_r[SAMPLE_BITS-1] ? inst_mag : -inst_mag;
        end
      end
      S_DIFF: begin
        diff_r <= XW'(inc_r) - XW'(inst_r);
      end
      S_CMP: begin
        if (hold) begin
          act_r <= ACT_HOLD;
        end else if (!diff_r[XW-1] && (diff_r != '0)) begin
          act_r <= ACT_UP;
        end else begin
          act_r <= ACT_DOWN;
        end
      end
      S_OUT: begin
        if (out_free) begin
          out_word_r.duty   <= duty_r;
          out_word_r.action <= act_r;
        end
      end
      default: ;
    endcase
  end

endmodule

/* rtl/icm_div.sv */
// Bit-serial restoring divider: (num << FRAC_BITS) / den, one quotient bit per cycle.
module icm_div
  import icm_pkg::*;
#(
  parameter int FRAC_BITS = FRAC_BITS_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            start,
  input  logic [SAMPLE_BITS-1:0]          num,
  input  logic [SAMPLE_BITS-1:0]          den,
  output logic                            done,
  output logic [SAMPLE_BITS+FRAC_BITS-1:0] quot
);

  localparam int QW = SAMPLE_BITS + FRAC_BITS;
  localparam int CW = $clog2(QW + 1);

  logic [QW-1:0]          num_sr_r;
  logic [QW-1:0]          quot_r;
  logic [SAMPLE_BITS-1:0] rem_r;
  logic [SAMPLE_BITS-1:0] den_r;
  logic [CW-1:0]          cnt_r;
  logic                   done_r;

  logic [SAMPLE_BITS:0]   trial;
  logic                   fits;

  // Bring down the next numerator bit and try the subtraction
  assign trial = {rem_r, num_sr_r[QW-1]};
  assign fits  = (trial >= {1'b0, den_r});

  // Count quotient bits, flag the last one
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r  <= '0;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        cnt_r <= CW'(QW);
      end else if (cnt_r != '0) begin
        cnt_r <= cnt_r - 1'b1;
        if (cnt_r == CW'(1)) begin
          done_r <= 1'b1;
        end
      end
    end
  end

  // Shift numerator out, quotient in
  always_ff @(posedge clk) begin
    if (start) begin
      num_sr_r <= {num, {FRAC_BITS{1'b0}}};
      rem_r    <= '0;
      den_r    <= den;
      quot_r   <= '0;
    end else if (cnt_r != '0) begin
      num_sr_r <= {num_sr_r[QW-2:0], 1'b0};
      rem_r    <= fits ? SAMPLE_BITS'(trial - {1'b0, den_r}) : trial[SAMPLE_BITS-1:0];
      quot_r   <= {quot_r[QW-2:0], fits};
    end
  end

  assign done = done_r;
  assign quot = quot_r;

endmodule

/* rtl/icm_regs.sv */
// Configuration register file for the tracker.
module icm_regs
  import icm_pkg::*;
(
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     cfg_valid,
  output logic                     cfg_ready,
  input  logic [CFG_IDX_BITS-1:0]  cfg_index,
  input  logic [CFG_DATA_BITS-1:0] cfg_data,
  output cfg_t                     cfg
);

  cfg_t cfg_r;

  // Always take writes; drop unknown indexes
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.duty_step     <= STEP_RST;
      cfg_r.tolerance_q16 <= TOLERANCE_RST;
      cfg_r.duty_lo       <= DUTY_LO_RST;
      cfg_r.duty_hi       <= DUTY_HI_RST;
      cfg_r.duty_init     <= INIT_DUTY_RST;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_STEP:      cfg_r.duty_step     <= cfg_data[3:0];
        CFG_TOLERANCE: cfg_r.tolerance_q16 <= cfg_data;
        CFG_DUTY_LO:   cfg_r.duty_lo       <= cfg_data[7:0];
        CFG_DUTY_HI:   cfg_r.duty_hi       <= cfg_data[7:0];
        CFG_DUTY_INIT: cfg_r.duty_init     <= cfg_data[7:0];
        default: ;
      endcase
    end
  end

  assign cfg = cfg_r;

endmodule
